### rtl/sm3_pkg.sv
// Package with SM3 constants, command/status types and round functions.
package sm3_pkg;

	localparam logic [31:0] T_LO = 32'h79CC4519;
	localparam logic [31:0] T_HI = 32'h7A879D8A;
	localparam logic [7:0]  PAD_BYTE = 8'h80;

	localparam logic [255:0] IV = {
		32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
		32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
	};

	// What the controller asks of the datapath each cycle.
	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_ABSORB,   // store input byte at fill pointer
		CMD_PAD_MARK, // store 0x80 at fill pointer
		CMD_PAD_ZERO, // store zero at fill pointer
		CMD_PAD_LEN,  // store length byte at fill pointer
		CMD_START,    // load message words and working registers
		CMD_ROUND,    // one compression round
		CMD_REARM     // reset chain value, counters
	} dp_op_t;

	typedef struct packed {
		dp_op_t      op;
		logic [7:0]  data;
		logic        finish; // fold working registers into chain on last round
	} dp_cmd_t;

	typedef struct packed {
		logic [5:0] fill;
		logic       round_last;
	} dp_stat_t;

	function automatic logic [31:0] rol(input logic [31:0] x, input logic [4:0] n);
		logic [63:0] d;
		d = {x, x} << n;
		return d[63:32];
	endfunction

	function automatic logic [31:0] p0(input logic [31:0] x);
		return x ^ rol(x, 5'd9) ^ rol(x, 5'd17);
	endfunction

	function automatic logic [31:0] p1(input logic [31:0] x);
		return x ^ rol(x, 5'd15) ^ rol(x, 5'd23);
	endfunction

endpackage

### rtl/sm3_datapath.sv
// SM3 datapath: block buffer, message schedule window, round logic, chain value.
module sm3_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  sm3_pkg::dp_cmd_t  cmd,
	output sm3_pkg::dp_stat_t stat,
	output logic [255:0]      chain
);

	logic [31:0]  buf_q [16];
	logic [5:0]   fill_q;
	logic [63:0]  bits_q;
	logic [255:0] chain_q;
	logic [31:0]  w_q [16];
	logic [5:0]   rnd_q;
	logic [31:0]  a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;

	logic [31:0] a12, ss1, ss2, tj, fx, gx, t1, t2, wnew, wp;
	logic [31:0] na, nb, nc, nd, ne, nf, ng, nh;
	logic [7:0]  len_byte;
	logic [2:0]  len_idx;
	logic [7:0]  wr_byte;
	logic        wr_en;
	logic [4:0]  lane_lsb;

	// Round function on the current window.
	always_comb begin
		tj   = (rnd_q < 6'd16) ? sm3_pkg::T_LO : sm3_pkg::T_HI;
		a12  = sm3_pkg::rol(a_q, 5'd12);
		ss1  = sm3_pkg::rol(a12 + e_q + sm3_pkg::rol(tj, rnd_q[4:0]), 5'd7);
		ss2  = ss1 ^ a12;
		if (rnd_q < 6'd16) begin
			fx = a_q ^ b_q ^ c_q;
			gx = e_q ^ f_q ^ g_q;
		end else begin
			fx = (a_q & b_q) | (a_q & c_q) | (b_q & c_q);
			gx = (e_q & f_q) | (~e_q & g_q);
		end
		wp   = w_q[0] ^ w_q[4];
		t1   = fx + d_q + ss2 + wp;
		t2   = gx + h_q + ss1 + w_q[0];
		wnew = sm3_pkg::p1(w_q[0] ^ w_q[7] ^ sm3_pkg::rol(w_q[13], 5'd15))
			^ sm3_pkg::rol(w_q[3], 5'd7) ^ w_q[10];
		na = t1; nb = a_q; nc = sm3_pkg::rol(b_q, 5'd9); nd = c_q;
		ne = sm3_pkg::p0(t2); nf = e_q; ng = sm3_pkg::rol(f_q, 5'd19); nh = g_q;
		len_idx  = fill_q[2:0];
		len_byte = bits_q[8'(7 - len_idx) * 8 +: 8];
		// Byte to store at the fill pointer; byte 0 of a word is its top lane.
		wr_en    = 1'b1;
		wr_byte  = 8'h00;
		lane_lsb = {~fill_q[1:0], 3'b000};
		case (cmd.op)
			sm3_pkg::CMD_ABSORB:   wr_byte = cmd.data;
			sm3_pkg::CMD_PAD_MARK: wr_byte = sm3_pkg::PAD_BYTE;
			sm3_pkg::CMD_PAD_ZERO: wr_byte = 8'h00;
			sm3_pkg::CMD_PAD_LEN:  wr_byte = len_byte;
			default:               wr_en = 1'b0;
		endcase
	end

	// Block buffer writes, one byte lane of one word at a time.
	always_ff @(posedge clk) begin
		if (wr_en)
			buf_q[fill_q[5:2]][lane_lsb +: 8] <= wr_byte;
	end

	// Schedule window and working registers.
	always_ff @(posedge clk) begin
		case (cmd.op)
			sm3_pkg::CMD_START: begin
				for (int i = 0; i < 16; i++)
					w_q[i] <= buf_q[i];
				{a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q} <= chain_q;
			end
			sm3_pkg::CMD_ROUND: begin
				for (int i = 0; i < 15; i++)
					w_q[i] <= w_q[i+1];
				w_q[15] <= wnew;
				{a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q} <= {na, nb, nc, nd, ne, nf, ng, nh};
			end
			default: ;
		endcase
	end

	// Control registers: fill pointer, bit count, round counter, chain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			bits_q  <= '0;
			rnd_q   <= '0;
			chain_q <= sm3_pkg::IV;
		end else begin
			case (cmd.op)
				sm3_pkg::CMD_ABSORB: begin
					fill_q <= fill_q + 6'd1;
					bits_q <= bits_q + 64'd8;
				end
				sm3_pkg::CMD_PAD_MARK, sm3_pkg::CMD_PAD_ZERO,
				sm3_pkg::CMD_PAD_LEN: fill_q <= fill_q + 6'd1;
				sm3_pkg::CMD_START: rnd_q <= '0;
				sm3_pkg::CMD_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (cmd.finish)
						chain_q <= chain_q ^ {na, nb, nc, nd, ne, nf, ng, nh};
				end
				sm3_pkg::CMD_REARM: begin
					fill_q  <= '0;
					bits_q  <= '0;
					chain_q <= sm3_pkg::IV;
				end
				default: ;
			endcase
		end
	end

	assign stat.fill       = fill_q;
	assign stat.round_last = (rnd_q == 6'd63);
	assign chain           = chain_q;

endmodule

### rtl/sm3_control.sv
// SM3 controller: input handshake, padding sequence, rounds and digest output.
module sm3_control (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        msg_byte,
	input  logic              last_byte,
	input  logic              no_data,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [2:0]        word_index,
	output logic              last_word,
	output sm3_pkg::dp_cmd_t  cmd,
	input  sm3_pkg::dp_stat_t stat
);

	typedef enum logic [2:0] {
		S_IDLE, S_START, S_ROUND, S_MARK, S_FILL, S_OUT
	} state_t;

	state_t     state_q;
	logic       final_q;   // compression is the last one: its result is the digest
	logic       pad_q;     // message ends: run padding after this block
	logic       len_ok_q;  // this padded block carries the length
	logic       tail_q;    // mark fell in the tail: a length-only block follows
	logic [2:0] idx_q;
	logic       take;

	assign in_stall   = (state_q != S_IDLE);
	assign take       = in_valid && !in_stall;
	assign out_valid  = (state_q == S_OUT);
	assign word_index = idx_q;
	assign last_word  = (idx_q == 3'd7);

	// Datapath command for this cycle.
	always_comb begin
		cmd.op     = sm3_pkg::CMD_NONE;
		cmd.data   = msg_byte;
		cmd.finish = 1'b0;
		case (state_q)
			S_IDLE:  if (take && !no_data) cmd.op = sm3_pkg::CMD_ABSORB;
			S_START: cmd.op = sm3_pkg::CMD_START;
			S_ROUND: begin
				cmd.op     = sm3_pkg::CMD_ROUND;
				cmd.finish = stat.round_last;
			end
			S_MARK:  cmd.op = sm3_pkg::CMD_PAD_MARK;
			S_FILL:  cmd.op = (len_ok_q && stat.fill >= 6'd56) ?
				sm3_pkg::CMD_PAD_LEN : sm3_pkg::CMD_PAD_ZERO;
			S_OUT:   if (!out_stall && last_word) cmd.op = sm3_pkg::CMD_REARM;
			default: ;
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			final_q  <= 1'b0;
			pad_q    <= 1'b0;
			len_ok_q <= 1'b0;
			tail_q   <= 1'b0;
			idx_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (take) begin
					pad_q   <= last_byte;
					final_q <= 1'b0;
					if (!no_data && stat.fill == 6'd63)
						state_q <= S_START;
					else if (last_byte)
						state_q <= S_MARK;
				end
				S_START: state_q <= S_ROUND;
				S_ROUND: if (stat.round_last) begin
					if (final_q) begin
						idx_q   <= '0;
						state_q <= S_OUT;
					end else if (pad_q)
						state_q <= S_MARK;
					else if (tail_q) begin
						// A mark that fell in the tail leaves a second, length-only block.
						tail_q   <= 1'b0;
						len_ok_q <= 1'b1;
						state_q  <= S_FILL;
					end else
						state_q <= S_IDLE;
				end
				S_MARK: begin
					pad_q    <= 1'b0;
					len_ok_q <= (stat.fill <= 6'd55);
					tail_q   <= (stat.fill > 6'd55);
					state_q  <= (stat.fill == 6'd63) ? S_START : S_FILL;
					final_q  <= (stat.fill <= 6'd55);
				end
				S_FILL: if (stat.fill == 6'd63) begin
					state_q <= S_START;
					final_q <= len_ok_q;
				end
				S_OUT: if (!out_stall) begin
					idx_q <= idx_q + 3'd1;
					if (last_word) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### rtl/sm3_hash_engine_core.sv
// Top level of the streaming SM3 hash engine.
//   channel | signals                                   | direction
//   input   | in_valid, in_stall, msg_byte, last_byte, no_data | into block
//   output  | out_valid, out_stall, digest_word, word_index, last_word | out of block
// A byte is taken only while the engine is idle; the 64th byte of a block starts
// a compression (load plus 64 rounds, one round per cycle).
// The last item adds padding writes and one or two compressions,
// then eight output transfers. Reset is asynchronous and needs no clearing pass.
// in_stall is high whenever the engine is busy; out_stall holds the current word.
module sm3_hash_engine_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  msg_byte,
	input  logic        last_byte,
	input  logic        no_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	sm3_pkg::dp_cmd_t  cmd;
	sm3_pkg::dp_stat_t stat;
	logic [255:0]      chain;

	sm3_control u_ctrl (
		.clk, .arst_n, .msg_byte, .last_byte, .no_data, .in_valid, .in_stall,
		.out_valid, .out_stall, .word_index, .last_word, .cmd, .stat
	);

	sm3_datapath u_dp (.clk, .arst_n, .cmd, .stat, .chain);

	assign digest_word = chain[255 - 32*word_index -: 32];

endmodule

### rtl/sm3_checker.sv
// Port-level checker for the SM3 engine, bound to the top level.
module sm3_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] digest_word,
	input logic [2:0]  word_index,
	input logic        last_word
);

	// The last flag marks word seven only.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_word == (word_index == 3'd7)))
		else $error("last_word mismatch");

	// Words come out in order.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_word |=>
			out_valid && word_index == $past(word_index) + 3'd1)
		else $error("word order broken");

	// No input is taken while a digest is being delivered.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open during output");

	// A stalled word holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(digest_word))
		else $error("stalled word changed");

endmodule

bind sm3_hash_engine_core sm3_checker u_chk (.*);
